FILE: hdl/dtt_pkg.sv
// Shared types and constants for the deadline timer table.
// Used by dtt_cell and deadline_timer_table_top; depends on nothing else.
package dtt_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int PERIOD_BITS = 32;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);

    typedef logic [SLOT_W-1:0]      slot_idx_t;
    typedef logic [PERIOD_BITS-1:0] period_t;
    typedef logic [63:0]            tstamp_t;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_RESET   = 3'd3;
    localparam logic [2:0] OP_EXPIRE  = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_INACTIVE = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_NONE     = 3'd3;
    localparam logic [2:0] STS_FIRED    = 3'd4;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ADD,
        CMD_CANCEL,
        CMD_REFRESH,
        CMD_RESET,
        CMD_MARK,
        CMD_FIRE
    } cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_SCAN,
        FSM_DECIDE
    } fsm_t;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_FRONT,
        PH_DUE,
        PH_QUERY
    } phase_t;

    typedef struct packed {
        cmd_t      cmd;
        slot_idx_t idx;
        tstamp_t   now;
        period_t   per;
        logic      rep;
        logic      fnow;
        logic      due_mode;
    } cell_cmd_t;

    typedef struct packed {
        logic      best_vld;
        tstamp_t   best_dl;
        slot_idx_t best_idx;
        logic      free_vld;
        slot_idx_t free_idx;
    } carry_t;

    typedef struct packed {
        logic    active;
        period_t period;
    } cell_stat_t;

endpackage

FILE: hdl/dtt_cell.sv
// One timer slot of the chain: holds its state and passes the running
// earliest/free search result to the next cell. Depends on dtt_pkg.
module dtt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  dtt_pkg::slot_idx_t cell_id,
    input  dtt_pkg::cell_cmd_t cmd,
    input  dtt_pkg::carry_t    carry_in,
    output dtt_pkg::carry_t    carry_out,
    output dtt_pkg::cell_stat_t stat
);

    logic             active_reg, active_next;
    logic             due_reg, due_next;
    logic             rep_reg, rep_next;
    dtt_pkg::period_t period_reg, period_next;
    dtt_pkg::tstamp_t deadline_reg, deadline_next;
    dtt_pkg::carry_t  carry_reg, carry_next;
    logic             hit;
    logic             consider;
    dtt_pkg::tstamp_t start;

    assign hit = (cmd.idx == cell_id);

    always_comb begin
        active_next   = active_reg;
        due_next      = due_reg;
        rep_next      = rep_reg;
        period_next   = period_reg;
        deadline_next = deadline_reg;
        start = cmd.fnow ? cmd.now : deadline_reg - 64'(period_reg);
        case (cmd.cmd)
            dtt_pkg::CMD_ADD: begin
                if (hit) begin
                    active_next   = 1'b1;
                    rep_next      = cmd.rep;
                    period_next   = cmd.per;
                    deadline_next = cmd.now + 64'(cmd.per);
                end
            end
            dtt_pkg::CMD_CANCEL: begin
                if (hit) begin
                    active_next = 1'b0;
                end
            end
            dtt_pkg::CMD_REFRESH: begin
                if (hit) begin
                    deadline_next = cmd.now + 64'(period_reg);
                end
            end
            dtt_pkg::CMD_RESET: begin
                if (hit) begin
                    period_next   = cmd.per;
                    deadline_next = start + 64'(cmd.per);
                end
            end
            dtt_pkg::CMD_MARK: begin
                due_next = active_reg && (deadline_reg <= cmd.now);
            end
            dtt_pkg::CMD_FIRE: begin
                if (hit) begin
                    due_next = 1'b0;
                    if (rep_reg) begin
                        deadline_next = cmd.now + 64'(period_reg);
                    end else begin
                        active_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // strict compare: lower slot keeps a tie since it sits earlier in the chain
    always_comb begin
        consider   = active_reg && (!cmd.due_mode || due_reg);
        carry_next = carry_in;
        if (consider && (!carry_in.best_vld || deadline_reg < carry_in.best_dl)) begin
            carry_next.best_vld = 1'b1;
            carry_next.best_dl  = deadline_reg;
            carry_next.best_idx = cell_id;
        end
        if (!carry_in.free_vld && !active_reg) begin
            carry_next.free_vld = 1'b1;
            carry_next.free_idx = cell_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            due_reg    <= 1'b0;
            carry_reg  <= '0;
        end else begin
            active_reg <= active_next;
            due_reg    <= due_next;
            carry_reg  <= carry_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_reg      <= rep_next;
        period_reg   <= period_next;
        deadline_reg <= deadline_next;
    end

    assign carry_out   = carry_reg;
    assign stat.active = active_reg;
    assign stat.period = period_reg;

endmodule

FILE: hdl/deadline_timer_table_top.sv
// Top level of the deadline timer table: control sequencer, output register
// and the chain of dtt_cell slots. Depends on dtt_pkg and dtt_cell.

// The table holds SLOT_COUNT timer slots in a chain of cells; every search for
// the earliest (or first free, or earliest due) slot ripples down the chain one
// cell per cycle. Cancel and refresh need no pass, query one, reset one when it
// changes the slot's timing, add a free-slot pass then a front pass, and expire
// one pass more than its k fired slots, with one result beat per fired slot (a
// single beat if none fires). A new item is taken only once the previous one is
// finished; results wait in the output register while the next item is accepted.
module deadline_timer_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [3:0]  s_slot_sel,
    input  logic [31:0] s_period_ms,
    input  logic        s_repeat_flag,
    input  logic        s_from_now,
    input  logic [63:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_slot_out,
    output logic        m_front_notice,
    output logic [63:0] m_next_delay,
    output logic        m_last
);

    dtt_pkg::fsm_t      state_reg, state_next;
    dtt_pkg::phase_t    phase_reg, phase_next;
    logic [dtt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic               notice_reg, notice_next;
    logic               have_prev_reg, have_prev_next;
    dtt_pkg::slot_idx_t prev_reg, prev_next;
    dtt_pkg::slot_idx_t alloc_reg, alloc_next;

    logic [2:0]         op_reg;
    logic [3:0]         sel_reg;
    dtt_pkg::period_t   per_reg;
    logic               rep_reg;
    logic               fnow_reg;
    dtt_pkg::tstamp_t   now_reg;

    logic               m_valid_reg, m_valid_next;
    logic [2:0]         status_reg, status_next;
    logic [3:0]         slot_reg, slot_next;
    logic               fn_reg, fn_next;
    logic [63:0]        delay_reg, delay_next;
    logic               last_reg, last_next;

    dtt_pkg::cell_cmd_t  cmd;
    dtt_pkg::carry_t     carry [dtt_pkg::SLOT_COUNT+1];
    dtt_pkg::cell_stat_t stat  [dtt_pkg::SLOT_COUNT];
    dtt_pkg::carry_t     res;

    logic               out_free;
    logic               scan_done;
    dtt_pkg::slot_idx_t sel_idx;
    logic               sel_ok;
    logic               unchanged;
    dtt_pkg::slot_idx_t target;
    logic               front;

    assign carry[0] = '0;
    assign res      = carry[dtt_pkg::SLOT_COUNT];

    for (genvar i = 0; i < dtt_pkg::SLOT_COUNT; i++) begin : g_cell
        dtt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_id   (dtt_pkg::SLOT_W'(i)),
            .cmd       (cmd),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .stat      (stat[i])
        );
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = (cnt_reg == dtt_pkg::CNT_W'(dtt_pkg::SLOT_COUNT));
    assign sel_idx   = dtt_pkg::SLOT_W'(sel_reg);
    assign sel_ok    = (32'(sel_reg) < dtt_pkg::SLOT_COUNT) && stat[sel_idx].active;
    assign unchanged = (per_reg == stat[sel_idx].period) && !fnow_reg;
    assign target    = (op_reg == dtt_pkg::OP_ADD) ? alloc_reg : sel_idx;
    assign front     = res.best_vld && (res.best_idx == target) && !notice_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dtt_pkg::FSM_IDLE: begin
                if (s_valid) begin
                    state_next = dtt_pkg::FSM_EXEC;
                end
            end
            dtt_pkg::FSM_EXEC: begin
                case (op_reg)
                    dtt_pkg::OP_ADD, dtt_pkg::OP_EXPIRE, dtt_pkg::OP_QUERY: begin
                        state_next = dtt_pkg::FSM_SCAN;
                    end
                    dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH: begin
                        if (out_free) begin
                            state_next = dtt_pkg::FSM_IDLE;
                        end
                    end
                    dtt_pkg::OP_RESET: begin
                        if (sel_ok && !unchanged) begin
                            state_next = dtt_pkg::FSM_SCAN;
                        end else if (out_free) begin
                            state_next = dtt_pkg::FSM_IDLE;
                        end
                    end
                    default: begin
                        state_next = dtt_pkg::FSM_IDLE;
                    end
                endcase
            end
            dtt_pkg::FSM_SCAN: begin
                if (scan_done) begin
                    state_next = dtt_pkg::FSM_DECIDE;
                end
            end
            dtt_pkg::FSM_DECIDE: begin
                case (phase_reg)
                    dtt_pkg::PH_FREE: begin
                        if (res.free_vld) begin
                            state_next = dtt_pkg::FSM_SCAN;
                        end else if (out_free) begin
                            state_next = dtt_pkg::FSM_IDLE;
                        end
                    end
                    dtt_pkg::PH_DUE: begin
                        if (res.best_vld) begin
                            if (!have_prev_reg || out_free) begin
                                state_next = dtt_pkg::FSM_SCAN;
                            end
                        end else if (out_free) begin
                            state_next = dtt_pkg::FSM_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            state_next = dtt_pkg::FSM_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                state_next = dtt_pkg::FSM_IDLE;
            end
        endcase
    end

    // outputs: cell commands, result beat loads, bookkeeping
    always_comb begin
        phase_next     = phase_reg;
        cnt_next       = (state_reg == dtt_pkg::FSM_SCAN) ? cnt_reg + 1'b1 : '0;
        notice_next    = notice_reg;
        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        alloc_next     = alloc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        fn_next        = fn_reg;
        delay_next     = delay_reg;
        last_next      = last_reg;
        cmd.cmd        = dtt_pkg::CMD_NONE;
        cmd.idx        = sel_idx;
        cmd.now        = now_reg;
        cmd.per        = per_reg;
        cmd.rep        = rep_reg;
        cmd.fnow       = fnow_reg;
        cmd.due_mode   = (phase_reg == dtt_pkg::PH_DUE);
        case (state_reg)
            dtt_pkg::FSM_EXEC: begin
                case (op_reg)
                    dtt_pkg::OP_ADD: begin
                        phase_next = dtt_pkg::PH_FREE;
                    end
                    dtt_pkg::OP_EXPIRE: begin
                        cmd.cmd        = dtt_pkg::CMD_MARK;
                        phase_next     = dtt_pkg::PH_DUE;
                        have_prev_next = 1'b0;
                    end
                    dtt_pkg::OP_QUERY: begin
                        phase_next = dtt_pkg::PH_QUERY;
                    end
                    dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH, dtt_pkg::OP_RESET: begin
                        if (sel_ok && !unchanged && op_reg == dtt_pkg::OP_RESET) begin
                            cmd.cmd    = dtt_pkg::CMD_RESET;
                            phase_next = dtt_pkg::PH_FRONT;
                        end else if (out_free) begin
                            if (sel_ok && op_reg == dtt_pkg::OP_CANCEL) begin
                                cmd.cmd = dtt_pkg::CMD_CANCEL;
                            end else if (sel_ok && op_reg == dtt_pkg::OP_REFRESH) begin
                                cmd.cmd = dtt_pkg::CMD_REFRESH;
                            end
                            m_valid_next = 1'b1;
                            status_next  = sel_ok ? dtt_pkg::STS_OK : dtt_pkg::STS_INACTIVE;
                            slot_next    = sel_reg;
                            fn_next      = 1'b0;
                            delay_next   = '0;
                            last_next    = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dtt_pkg::FSM_DECIDE: begin
                case (phase_reg)
                    dtt_pkg::PH_FREE: begin
                        if (res.free_vld) begin
                            cmd.cmd    = dtt_pkg::CMD_ADD;
                            cmd.idx    = res.free_idx;
                            alloc_next = res.free_idx;
                            phase_next = dtt_pkg::PH_FRONT;
                        end else if (out_free) begin
                            m_valid_next = 1'b1;
                            status_next  = dtt_pkg::STS_FULL;
                            slot_next    = '0;
                            fn_next      = 1'b0;
                            delay_next   = '0;
                            last_next    = 1'b1;
                        end
                    end
                    dtt_pkg::PH_FRONT: begin
                        if (out_free) begin
                            if (front) begin
                                notice_next = 1'b1;
                            end
                            m_valid_next = 1'b1;
                            status_next  = dtt_pkg::STS_OK;
                            slot_next    = 4'(target);
                            fn_next      = front;
                            delay_next   = '0;
                            last_next    = 1'b1;
                        end
                    end
                    dtt_pkg::PH_DUE: begin
                        // hold the fired slot back one pass to learn whether it is the last
                        if (res.best_vld) begin
                            if (!have_prev_reg || out_free) begin
                                cmd.cmd        = dtt_pkg::CMD_FIRE;
                                cmd.idx        = res.best_idx;
                                prev_next      = res.best_idx;
                                have_prev_next = 1'b1;
                                if (have_prev_reg) begin
                                    m_valid_next = 1'b1;
                                    status_next  = dtt_pkg::STS_FIRED;
                                    slot_next    = 4'(prev_reg);
                                    fn_next      = 1'b0;
                                    delay_next   = '0;
                                    last_next    = 1'b0;
                                end
                            end
                        end else if (out_free) begin
                            m_valid_next = 1'b1;
                            status_next  = have_prev_reg ? dtt_pkg::STS_FIRED
                                                         : dtt_pkg::STS_NONE;
                            slot_next    = have_prev_reg ? 4'(prev_reg) : 4'd0;
                            fn_next      = 1'b0;
                            delay_next   = '0;
                            last_next    = 1'b1;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            notice_next  = 1'b0;
                            m_valid_next = 1'b1;
                            status_next  = dtt_pkg::STS_OK;
                            fn_next      = 1'b0;
                            last_next    = 1'b1;
                            if (!res.best_vld) begin
                                slot_next  = '0;
                                delay_next = '1;
                            end else begin
                                slot_next  = 4'(res.best_idx);
                                delay_next = (now_reg >= res.best_dl) ? 64'd0
                                                                      : res.best_dl - now_reg;
                            end
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dtt_pkg::FSM_IDLE;
            phase_reg     <= dtt_pkg::PH_FREE;
            cnt_reg       <= '0;
            notice_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            notice_reg    <= notice_next;
            have_prev_reg <= have_prev_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg   <= prev_next;
        alloc_reg  <= alloc_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        fn_reg     <= fn_next;
        delay_reg  <= delay_next;
        last_reg   <= last_next;
        if (s_valid && s_ready) begin
            op_reg   <= s_op;
            sel_reg  <= s_slot_sel;
            per_reg  <= dtt_pkg::PERIOD_BITS'(s_period_ms);
            rep_reg  <= s_repeat_flag;
            fnow_reg <= s_from_now;
            now_reg  <= s_now_ms;
        end
    end

    assign s_ready        = (state_reg == dtt_pkg::FSM_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_slot_out     = slot_reg;
    assign m_front_notice = fn_reg;
    assign m_next_delay   = delay_reg;
    assign m_last         = last_reg;

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dtt_pkg::FSM_SCAN |-> cnt_reg <= dtt_pkg::CNT_W'(dtt_pkg::SLOT_COUNT))
        else $error("chain scan counter overran the chain length");

    a_notice_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_front_notice |-> notice_reg)
        else $error("front notice shown while no notice is pending");

    a_item_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == dtt_pkg::FSM_EXEC)
        else $error("accepted item did not start execution");

endmodule

FILE: sim/dtt_checker.sv
// Scoreboard for the deadline timer table: watches both channels, keeps its own
// copy of the timer slots and compares every result beat. Depends on dtt_pkg.
`timescale 1ns / 1ps

module dtt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [3:0]  s_slot_sel,
    input  logic [31:0] s_period_ms,
    input  logic        s_repeat_flag,
    input  logic        s_from_now,
    input  logic [63:0] s_now_ms,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [3:0]  m_slot_out,
    input  logic        m_front_notice,
    input  logic [63:0] m_next_delay,
    input  logic        m_last,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic        notice;
        logic [63:0] delay;
        logic        last;
    } timer_beat_t;

    logic             tm_active [dtt_pkg::SLOT_COUNT];
    logic             tm_repeat [dtt_pkg::SLOT_COUNT];
    dtt_pkg::period_t tm_period [dtt_pkg::SLOT_COUNT];
    dtt_pkg::tstamp_t tm_deadline [dtt_pkg::SLOT_COUNT];
    logic             tm_notice;

    timer_beat_t beat_q[$];

    assign pending_count = beat_q.size();

    function automatic bit orders_first(int a, int b);
        if (tm_deadline[a] != tm_deadline[b])
            return tm_deadline[a] < tm_deadline[b];
        return a < b;
    endfunction

    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < dtt_pkg::SLOT_COUNT; i++)
            if (tm_active[i] && (best < 0 || orders_first(i, best)))
                best = i;
        return best;
    endfunction

    function automatic logic take_notice(int s);
        if (earliest_slot() == s && !tm_notice) begin
            tm_notice = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_beat(logic [2:0] st, int sl, logic fn, logic [63:0] d,
                                      logic lst);
        timer_beat_t b;
        b.status = st;
        b.slot   = sl[3:0];
        b.notice = fn;
        b.delay  = d;
        b.last   = lst;
        beat_q = {beat_q, b};
    endfunction

    task automatic predict_timer_op(logic [2:0] op, int s, dtt_pkg::period_t per, logic rep,
                                    logic fnow, dtt_pkg::tstamp_t now);
        int               f;
        int               n;
        int               e;
        int               best;
        int               order [dtt_pkg::SLOT_COUNT];
        logic             due [dtt_pkg::SLOT_COUNT];
        logic             ok;
        dtt_pkg::tstamp_t start;
        ok = tm_active[s];
        case (op)
            dtt_pkg::OP_ADD: begin
                f = -1;
                for (int i = dtt_pkg::SLOT_COUNT - 1; i >= 0; i--)
                    if (!tm_active[i]) f = i;
                if (f < 0) begin
                    push_beat(dtt_pkg::STS_FULL, 0, 0, 0, 1);
                end else begin
                    tm_active[f]   = 1;
                    tm_repeat[f]   = rep;
                    tm_period[f]   = per;
                    tm_deadline[f] = now + 64'(per);
                    push_beat(dtt_pkg::STS_OK, f, take_notice(f), 0, 1);
                end
            end
            dtt_pkg::OP_CANCEL: begin
                if (ok) tm_active[s] = 0;
                push_beat(ok ? dtt_pkg::STS_OK : dtt_pkg::STS_INACTIVE, s, 0, 0, 1);
            end
            dtt_pkg::OP_REFRESH: begin
                if (ok) tm_deadline[s] = now + 64'(tm_period[s]);
                push_beat(ok ? dtt_pkg::STS_OK : dtt_pkg::STS_INACTIVE, s, 0, 0, 1);
            end
            dtt_pkg::OP_RESET: begin
                if (!ok) begin
                    push_beat(dtt_pkg::STS_INACTIVE, s, 0, 0, 1);
                end else if (per == tm_period[s] && !fnow) begin
                    push_beat(dtt_pkg::STS_OK, s, 0, 0, 1);
                end else begin
                    start = fnow ? now : tm_deadline[s] - 64'(tm_period[s]);
                    tm_period[s]   = per;
                    tm_deadline[s] = start + 64'(per);
                    push_beat(dtt_pkg::STS_OK, s, take_notice(s), 0, 1);
                end
            end
            dtt_pkg::OP_EXPIRE: begin
                n = 0;
                for (int i = 0; i < dtt_pkg::SLOT_COUNT; i++)
                    due[i] = tm_active[i] && tm_deadline[i] <= now;
                forever begin
                    best = -1;
                    for (int i = 0; i < dtt_pkg::SLOT_COUNT; i++)
                        if (due[i] && (best < 0 || orders_first(i, best))) best = i;
                    if (best < 0) break;
                    due[best] = 0;
                    order[n] = best;
                    n = n + 1;
                end
                if (n == 0) push_beat(dtt_pkg::STS_NONE, 0, 0, 0, 1);
                for (int k = 0; k < n; k++) begin
                    push_beat(dtt_pkg::STS_FIRED, order[k], 0, 0, k == n - 1);
                    if (tm_repeat[order[k]])
                        tm_deadline[order[k]] = now + 64'(tm_period[order[k]]);
                    else
                        tm_active[order[k]] = 0;
                end
            end
            dtt_pkg::OP_QUERY: begin
                e = earliest_slot();
                tm_notice = 0;
                if (e < 0)
                    push_beat(dtt_pkg::STS_OK, 0, 0, '1, 1);
                else
                    push_beat(dtt_pkg::STS_OK, e, 0,
                              now >= tm_deadline[e] ? 64'd0 : tm_deadline[e] - now, 1);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        timer_beat_t got;
        timer_beat_t want;
        if (!aresetn) begin
            for (int i = 0; i < dtt_pkg::SLOT_COUNT; i++) begin
                tm_active[i]   = 0;
                tm_repeat[i]   = 0;
                tm_period[i]   = '0;
                tm_deadline[i] = '0;
            end
            tm_notice  = 0;
            fail_count = 0;
            beat_q.delete();
        end else begin
            // check the output before predicting: a new item's beats trail older ones
            if (m_valid && m_ready) begin
                got = '{m_status, m_slot_out, m_front_notice, m_next_delay, m_last};
                if (beat_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected beat %p", $realtime, got);
                end else begin
                    want = beat_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (s_valid && s_ready)
                predict_timer_op(s_op, int'(s_slot_sel), s_period_ms, s_repeat_flag,
                                 s_from_now, s_now_ms);
        end
    end

endmodule

FILE: sim/tb_top.sv
// Stimulus and verdict for the deadline timer table: drives timer operations in
// bursts, stalls the result side, and reads the failure count of dtt_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_op;
    logic [3:0]  s_slot_sel;
    logic [31:0] s_period_ms;
    logic        s_repeat_flag;
    logic        s_from_now;
    logic [63:0] s_now_ms;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [3:0]  m_slot_out;
    logic        m_front_notice;
    logic [63:0] m_next_delay;
    logic        m_last;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    logic        hold_off;
    logic [63:0] clock_ms;

    deadline_timer_table_top dut (.*);
    dtt_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: its own stall pattern, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_off)
            m_ready <= 0;
        else
            m_ready <= ($urandom_range(0, 9) > 2) || (cycle_count[9:8] == 2'b01);
    end

    task automatic send_op(logic [2:0] op, logic [3:0] sel, logic [31:0] per,
                           logic rep, logic fnow, logic [63:0] now);
        s_valid       <= 1;
        s_op          <= op;
        s_slot_sel    <= sel;
        s_period_ms   <= per;
        s_repeat_flag <= rep;
        s_from_now    <= fnow;
        s_now_ms      <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 0;
            2: return $urandom;
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    task automatic random_op();
        logic [2:0] op;
        logic [63:0] now;
        // time mostly advances slowly so that timers come due
        clock_ms = clock_ms + 64'($urandom_range(0, 60));
        now = clock_ms;
        if ($urandom_range(0, 19) == 0) now = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: op = dtt_pkg::OP_ADD;
            3: op = dtt_pkg::OP_CANCEL;
            4: op = dtt_pkg::OP_REFRESH;
            5: op = dtt_pkg::OP_RESET;
            6, 7: op = dtt_pkg::OP_EXPIRE;
            8: op = dtt_pkg::OP_QUERY;
            default: begin
                if ($urandom_range(0, 3) == 0)
                    op = ($urandom_range(0, 1) == 0) ? 3'd6 : 3'd7;
                else
                    op = dtt_pkg::OP_QUERY;
            end
        endcase
        send_op(op, 4'($urandom_range(0, 15)), pick_period(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), now);
    endtask

    initial begin
        hold_off      = 0;
        clock_ms      = 1000;
        aresetn       = 0;
        s_valid       = 0;
        s_op          = dtt_pkg::OP_QUERY;
        s_slot_sel    = 0;
        s_period_ms   = 0;
        s_repeat_flag = 0;
        s_from_now    = 0;
        s_now_ms      = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty table, inactive slots, wrap, full table, ties
        send_op(dtt_pkg::OP_QUERY, 0, 0, 0, 0, 0);
        send_op(dtt_pkg::OP_EXPIRE, 0, 0, 0, 0, '1);
        send_op(dtt_pkg::OP_CANCEL, 15, 0, 0, 0, 5);
        send_op(dtt_pkg::OP_REFRESH, 3, 0, 0, 0, 5);
        send_op(dtt_pkg::OP_RESET, 7, 9, 0, 1, 5);
        send_op(dtt_pkg::OP_ADD, 0, 32'hFFFF_FFFF, 1, 0, 64'hFFFF_FFFF_FFFF_FFF0);
        send_op(dtt_pkg::OP_ADD, 0, 0, 0, 0, 100);
        send_op(dtt_pkg::OP_QUERY, 0, 0, 0, 0, 50);
        for (int i = 0; i < 15; i++)
            send_op(dtt_pkg::OP_ADD, 0, 10, i[0], 0, 100);
        send_op(dtt_pkg::OP_RESET, 2, 10, 0, 0, 100);
        send_op(dtt_pkg::OP_RESET, 2, 5, 0, 0, 100);
        send_op(dtt_pkg::OP_RESET, 3, 5, 1, 1, 90);
        send_op(dtt_pkg::OP_REFRESH, 4, 0, 0, 0, 95);
        send_op(dtt_pkg::OP_EXPIRE, 0, 0, 0, 0, 110);
        send_op(dtt_pkg::OP_QUERY, 0, 0, 0, 0, 200);
        send_op(3'd7, 0, 0, 0, 0, 0);
        send_op(dtt_pkg::OP_EXPIRE, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 16; i++)
            send_op(dtt_pkg::OP_CANCEL, 4'(i), 0, 0, 0, 0);
        drain_results();

        // long receiver hold-off while items keep coming
        hold_off <= 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off <= 0;
            end
            for (int i = 0; i < 6; i++) random_op();
        join

        for (int i = 0; i < 130; i++) begin
            random_op();
            idle_gap();
            if (i == 65) drain_results();
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dtt_pkg.sv
hdl/dtt_cell.sv
hdl/deadline_timer_table_top.sv
sim/dtt_checker.sv
sim/tb_top.sv
